// File: sv/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg
// Shared types, codes and constants of the cartridge save RAM / EEPROM mapper.
// ----------------------------------------------------------------------------
package csem_pkg;

    // save RAM depth in words
    localparam int RAM_WORDS_DEF = 32768;

    // bus operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_IO    = 2'd2;

    // save RAM kinds
    localparam logic [1:0] RK_NONE  = 2'd0;
    localparam logic [1:0] RK_WORD  = 2'd1;
    localparam logic [1:0] RK_UPPER = 2'd2;
    localparam logic [1:0] RK_LOWER = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_KIND       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EEPROM_PRESENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_WORDS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SDA_BIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SDA_BIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SCL_BIT  = 3'd5;
    localparam int CFG_DATA_W = 22;

    // address map and fixed values
    localparam logic [23:0] IO_RAM_CTRL_ADDR = 24'hA130F0;
    localparam logic [15:0] ROM_OOB_WORD     = 16'hFFFF;
    localparam logic [21:0] ROM_WORDS_RST    = 22'h200000;
    localparam logic [21:0] SMALL_ROM_WORDS  = 22'h100000;
    localparam logic [3:0]  SCL_BIT_RST      = 4'd1;

    // stream widths
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 24;

    // front to back queue
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  ram_kind;
        logic        eeprom_present;
        logic [21:0] rom_words;
        logic [3:0]  read_sda_bit;
        logic [3:0]  write_sda_bit;
        logic [3:0]  write_scl_bit;
    } csem_cfg_t;

    // one classified bus access
    typedef struct packed {
        logic [1:0]  op;
        logic        upper;
        logic        lower;
        logic        in_window;
        logic        hi_area;
        logic        rom_oob;
        logic        io_ram_sel;
        logic [15:0] write_data;
        logic [15:0] read_merge;
        logic [15:0] rom_word;
        logic        scl_hit;
        logic        scl_val;
        logic        sda_hit;
        logic        sda_val;
    } csem_item_t;

    function automatic int csem_slot_w(input int words);
        return (words > 1) ? $clog2(words) : 1;
    endfunction

endpackage

// File: sv/csem_ram.sv
// ----------------------------------------------------------------------------
// csem_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module csem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/csem_front.sv
// ----------------------------------------------------------------------------
// csem_front
// Accepts bus accesses, classifies them and works out the save RAM slot.
// ----------------------------------------------------------------------------
module csem_front
    import csem_pkg::*;
#(
    parameter int RAM_WORDS = RAM_WORDS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  csem_cfg_t                           cfg,
    input  logic                                clearing,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [IN_TUSER_W-1:0]               s_tuser,
    input  logic [IN_TDATA_W-1:0]               s_tdata,
    output logic                                q_valid,
    output csem_item_t                          q_item,
    output logic [csem_slot_w(RAM_WORDS)-1:0]   q_slot,
    input  logic                                q_ready
);

    localparam int SLOT_W = csem_slot_w(RAM_WORDS);
    // exact reciprocal for a 21-bit word index
    localparam int SHIFT = 21 + $clog2(RAM_WORDS);
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + RAM_WORDS - 1) / RAM_WORDS;
    localparam logic [22:0] RECIP_C = RECIP[22:0];
    localparam logic [20:0] WORDS_C = 21'(RAM_WORDS);

    logic        v1_reg, v1_next;
    csem_item_t  item1_reg, item1_next;
    logic [20:0] x1_reg;
    logic [43:0] prod1_reg;

    logic        up, lo, sda_in, take, rd_hit, scl_hit, sda_hit;
    logic [1:0]  op;
    logic [23:0] addr;
    logic [15:0] data, rom;
    logic [20:0] x, quot, rem;

    assign op     = s_tuser[1:0];
    assign up     = s_tdata[0];
    assign lo     = s_tdata[1];
    assign addr   = s_tdata[25:2];
    assign data   = s_tdata[41:26];
    assign sda_in = s_tdata[42];
    assign rom    = s_tdata[58:43];
    assign x      = addr[21:1];

    assign rd_hit  = (up && cfg.read_sda_bit[3]) || (lo && !cfg.read_sda_bit[3]);
    assign scl_hit = (up && cfg.write_scl_bit[3]) || (lo && !cfg.write_scl_bit[3]);
    assign sda_hit = (up && cfg.write_sda_bit[3]) || (lo && !cfg.write_sda_bit[3]);

    assign s_tready = !clearing && (!v1_reg || q_ready);
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        item1_next            = item1_reg;
        v1_next               = v1_reg;
        if (q_ready)
        begin
            v1_next = 1'b0;
        end
        if (take)
        begin
            v1_next               = 1'b1;
            item1_next.op         = op;
            item1_next.upper      = up;
            item1_next.lower      = lo;
            item1_next.in_window  = addr[21] && !addr[20];
            item1_next.hi_area    = addr[21];
            item1_next.rom_oob    = ({1'b0, x} >= cfg.rom_words);
            item1_next.io_ram_sel = (op == OP_IO) && lo && (addr == IO_RAM_CTRL_ADDR);
            item1_next.write_data = data;
            item1_next.read_merge = rd_hit
                ? ((data & ~(16'd1 << cfg.read_sda_bit)) | (16'(sda_in) << cfg.read_sda_bit))
                : data;
            item1_next.rom_word   = rom;
            item1_next.scl_hit    = scl_hit;
            item1_next.scl_val    = data[cfg.write_scl_bit];
            item1_next.sda_hit    = sda_hit;
            item1_next.sda_val    = data[cfg.write_sda_bit];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item1_reg <= item1_next;
        if (take)
        begin
            x1_reg    <= x;
            prod1_reg <= 44'(x) * 44'(RECIP_C);
        end
    end

    // remainder from the registered quotient estimate
    assign quot = 21'(prod1_reg >> SHIFT);
    assign rem  = x1_reg - 21'(42'(quot) * 42'(WORDS_C));

    assign q_valid = v1_reg;
    assign q_item  = item1_reg;
    assign q_slot  = rem[SLOT_W-1:0];

endmodule

// File: sv/csem_queue.sv
// ----------------------------------------------------------------------------
// csem_queue
// Short FIFO of classified accesses between the front and the back.
// ----------------------------------------------------------------------------
module csem_queue
    import csem_pkg::*;
#(
    parameter int SLOT_W = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  csem_item_t        in_item,
    input  logic [SLOT_W-1:0] in_slot,
    output logic              out_valid,
    input  logic              out_ready,
    output csem_item_t        out_item,
    output logic [SLOT_W-1:0] out_slot
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    csem_item_t        item_mem [QUEUE_DEPTH];
    logic [SLOT_W-1:0] slot_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = item_mem[rd_ptr_reg];
    assign out_slot  = slot_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_mem[wr_ptr_reg] <= in_item;
            slot_mem[wr_ptr_reg] <= in_slot;
        end
    end

endmodule

// File: sv/csem_back.sv
// ----------------------------------------------------------------------------
// csem_back
// Carries out accesses: save RAM, EEPROM pins, ROM reads, output register.
// ----------------------------------------------------------------------------
module csem_back
    import csem_pkg::*;
#(
    parameter int RAM_WORDS = RAM_WORDS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  csem_cfg_t                         cfg,
    input  logic                              rom_wr,
    input  logic [21:0]                       rom_wr_words,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  csem_item_t                        q_item,
    input  logic [csem_slot_w(RAM_WORDS)-1:0] q_slot,
    output logic                              clearing,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_TDATA_W-1:0]            m_tdata
);

    localparam int SLOT_W = csem_slot_w(RAM_WORDS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RAM_WORDS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } back_state_t;

    back_state_t       state_reg, state_next;
    logic [SLOT_W-1:0] clr_cnt_reg, clr_cnt_next;
    csem_item_t        item_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              ram_en_reg, ram_en_next;
    logic              eep_en_reg, eep_en_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              out_valid_reg, out_valid_next;
    logic [15:0]       out_rd_reg, out_rd_next;
    logic              out_scl_reg, out_scl_next;
    logic              out_sda_reg, out_sda_next;
    logic              out_clk_reg, out_clk_next;

    logic              pop, small_rom;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata, ram_rdata, merged;

    assign pop       = (state_reg == ST_IDLE) && q_valid && (!out_valid_reg || m_tready);
    assign q_ready   = pop;
    assign clearing  = (state_reg == ST_CLEAR);
    assign small_rom = (cfg.rom_words <= SMALL_ROM_WORDS);

    csem_ram #(
        .WIDTH (16),
        .DEPTH (RAM_WORDS)
    ) u_save_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (pop),
        .raddr (q_slot),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        merged = ram_rdata;
        if (item_reg.upper)
        begin
            merged[15:8] = item_reg.write_data[15:8];
        end
        if (item_reg.lower)
        begin
            merged[7:0] = item_reg.write_data[7:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        ram_en_next    = ram_en_reg;
        eep_en_next    = eep_en_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        out_valid_next = out_valid_reg;
        out_rd_next    = out_rd_reg;
        out_scl_next   = out_scl_reg;
        out_sda_next   = out_sda_reg;
        out_clk_next   = out_clk_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = merged;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next   = ST_IDLE;
                out_rd_next  = '0;
                out_clk_next = 1'b0;
                case (item_reg.op)
                    OP_READ:
                    begin
                        if (item_reg.in_window && ram_en_reg && cfg.ram_kind == RK_WORD)
                        begin
                            out_rd_next = ram_rdata;
                        end
                        else if (item_reg.in_window && ram_en_reg
                                 && (cfg.ram_kind == RK_UPPER || cfg.ram_kind == RK_LOWER))
                        begin
                            out_rd_next = {ram_rdata[7:0], ram_rdata[7:0]};
                        end
                        else if (item_reg.in_window && cfg.eeprom_present && eep_en_reg)
                        begin
                            out_rd_next = item_reg.read_merge;
                        end
                        else if (item_reg.rom_oob)
                        begin
                            out_rd_next = ROM_OOB_WORD;
                        end
                        else
                        begin
                            out_rd_next = item_reg.rom_word;
                        end
                    end
                    OP_WRITE:
                    begin
                        if (!item_reg.hi_area)
                        begin
                            out_clk_next = 1'b0;
                        end
                        else if (ram_en_reg && cfg.ram_kind == RK_WORD)
                        begin
                            ram_we = 1'b1;
                        end
                        else if (ram_en_reg && cfg.ram_kind == RK_UPPER)
                        begin
                            ram_we    = item_reg.upper;
                            ram_wdata = {8'h00, item_reg.write_data[7:0]};
                        end
                        else if (ram_en_reg && cfg.ram_kind == RK_LOWER)
                        begin
                            ram_we    = item_reg.lower;
                            ram_wdata = {8'h00, item_reg.write_data[7:0]};
                        end
                        else if (!cfg.eeprom_present)
                        begin
                            out_clk_next = 1'b0;
                        end
                        else if (!small_rom && item_reg.upper && item_reg.lower)
                        begin
                            eep_en_next = !item_reg.write_data[0];
                        end
                        else if (eep_en_reg)
                        begin
                            out_clk_next = 1'b1;
                            if (item_reg.scl_hit)
                            begin
                                scl_next = item_reg.scl_val;
                            end
                            if (item_reg.sda_hit)
                            begin
                                sda_next = item_reg.sda_val;
                            end
                        end
                    end
                    OP_IO:
                    begin
                        if (item_reg.io_ram_sel)
                        begin
                            ram_en_next = item_reg.write_data[0];
                        end
                    end
                    default:
                    begin
                        out_rd_next = '0;
                    end
                endcase
                out_scl_next   = scl_next;
                out_sda_next   = sda_next;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // size rewrite sets the enable as at power-up
        if (rom_wr)
        begin
            eep_en_next = (rom_wr_words <= SMALL_ROM_WORDS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            ram_en_reg    <= 1'b1;
            eep_en_reg    <= (ROM_WORDS_RST <= SMALL_ROM_WORDS);
            scl_reg       <= 1'b0;
            sda_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            ram_en_reg    <= ram_en_next;
            eep_en_reg    <= eep_en_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= q_item;
            slot_reg <= q_slot;
        end
        out_rd_reg  <= out_rd_next;
        out_scl_reg <= out_scl_next;
        out_sda_reg <= out_sda_next;
        out_clk_reg <= out_clk_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_clk_reg, out_sda_reg, out_scl_reg, out_rd_reg};

`ifndef SYNTHESIS
    a_no_pop_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !q_ready)
        else $error("queue popped during save RAM clear");

    a_exec_slot_free : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> !out_valid_reg)
        else $error("execute with output register still full");

    a_exec_one_cycle : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> (state_reg == ST_IDLE))
        else $error("execute state did not return to idle");

    a_ram_write_kind : assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == ST_EXEC) |-> (item_reg.op == OP_WRITE && item_reg.hi_area))
        else $error("save RAM written by an access that is not a RAM write");

    a_pop_to_exec : assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |=> (state_reg == ST_EXEC))
        else $error("popped item not executed next cycle");
`endif

endmodule

// File: sv/cartridge_sram_eeprom_mapper_core.sv
// ----------------------------------------------------------------------------
// cartridge_sram_eeprom_mapper_core
// Cartridge bus mapper with save RAM and a bit-banged serial EEPROM port.
//
//   channel   | direction | handshake                      | payload
//   ----------+-----------+--------------------------------+--------------------------
//   s_axis    | in        | s_axis_tvalid / s_axis_tready  | tuser op, tdata access
//   m_axis    | out       | m_axis_tvalid / m_axis_tready  | tdata result
//   cfg       | in        | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// an access passes the front register and the queue, then in the back it goes
// through save RAM read issue, then execute with the registered RAM data
// the back takes no new access before the last one is executed, set by the
// save RAM read-modify-write; a full output register not taken also holds it
// after reset the back clears every save RAM word, with s_axis_tready
// low; configuration transfers are always taken
// a result waits in the output register while up to three more accesses
// are held in the front register and the queue
// ----------------------------------------------------------------------------
module cartridge_sram_eeprom_mapper_core
    import csem_pkg::*;
#(
    parameter int RAM_WORDS = RAM_WORDS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // operation[1:0]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    // upper_lane[0], lower_lane[1], address[25:2], write_data[41:26],
    // eeprom_sda_in[42], rom_word[58:43], zero fill above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // read_data[15:0], scl_level[16], sda_level[17], eeprom_clocked[18], zero fill above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SLOT_W = csem_slot_w(RAM_WORDS);

    csem_cfg_t         cfg_reg, cfg_next;
    logic              cfg_wr, rom_wr, clearing;
    logic              f_valid, f_ready, b_valid, b_ready;
    csem_item_t        f_item, b_item;
    logic [SLOT_W-1:0] f_slot, b_slot;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign rom_wr    = cfg_wr && (cfg_index == CFG_ROM_WORDS);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                CFG_RAM_KIND:       cfg_next.ram_kind       = cfg_data[1:0];
                CFG_EEPROM_PRESENT: cfg_next.eeprom_present = cfg_data[0];
                CFG_ROM_WORDS:      cfg_next.rom_words      = cfg_data[21:0];
                CFG_READ_SDA_BIT:   cfg_next.read_sda_bit   = cfg_data[3:0];
                CFG_WRITE_SDA_BIT:  cfg_next.write_sda_bit  = cfg_data[3:0];
                CFG_WRITE_SCL_BIT:  cfg_next.write_scl_bit  = cfg_data[3:0];
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ram_kind       <= RK_NONE;
            cfg_reg.eeprom_present <= 1'b0;
            cfg_reg.rom_words      <= ROM_WORDS_RST;
            cfg_reg.read_sda_bit   <= '0;
            cfg_reg.write_sda_bit  <= '0;
            cfg_reg.write_scl_bit  <= SCL_BIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    csem_front #(
        .RAM_WORDS (RAM_WORDS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .clearing (clearing),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tuser  (s_axis_tuser),
        .s_tdata  (s_axis_tdata),
        .q_valid  (f_valid),
        .q_item   (f_item),
        .q_slot   (f_slot),
        .q_ready  (f_ready)
    );

    csem_queue #(
        .SLOT_W (SLOT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .in_slot   (f_slot),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item),
        .out_slot  (b_slot)
    );

    csem_back #(
        .RAM_WORDS (RAM_WORDS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .rom_wr       (rom_wr),
        .rom_wr_words (cfg_data[21:0]),
        .q_valid      (b_valid),
        .q_ready      (b_ready),
        .q_item       (b_item),
        .q_slot       (b_slot),
        .clearing     (clearing),
        .m_tvalid     (m_axis_tvalid),
        .m_tready     (m_axis_tready),
        .m_tdata      (m_axis_tdata)
    );

endmodule
